@@ rtl/pil_pkg.sv @@
// Package for the positional insert/erase list.
// Holds the sizes, command and status codes, and the cell select type.
// No dependencies.
`default_nettype none

package pil_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CMD_W       = 2;
    localparam int POS_W       = 5;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]       count_t;
    typedef logic [CMP_W-1:0]       cmp_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_READ   = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_INSERT = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SEL_HOLD      = 2'd0,
        SEL_LOAD      = 2'd1,
        SEL_FROM_LOW  = 2'd2,
        SEL_FROM_HIGH = 2'd3
    } cell_sel_t;

endpackage

`default_nettype wire

@@ rtl/pil_cell.sv @@
// One storage cell of the positional insert/erase list.
// Holds one word and loads a new word or a neighbor's word; uses pil_pkg.
`default_nettype none

module pil_cell
    import pil_pkg::*;
(
    input  wire logic      aclk,
    input  wire cell_sel_t sel,
    input  wire value_t    new_value,
    input  wire value_t    low_value,
    input  wire value_t    high_value,
    output value_t         data
);

    value_t data_reg;

    always_ff @(posedge aclk) begin
        unique case (sel)
            SEL_HOLD:      data_reg <= data_reg;
            SEL_LOAD:      data_reg <= new_value;
            SEL_FROM_LOW:  data_reg <= low_value;
            SEL_FROM_HIGH: data_reg <= high_value;
            default:       data_reg <= data_reg;
        endcase
    end

    assign data = data_reg;

endmodule

`default_nettype wire

@@ rtl/positional_insert_erase_list.sv @@
// Positional insert/erase list: a row of cells, one word each, that shift
// together to carry out append, read, erase and insert. The result is
// registered and appears in the cycle after the input transfer. Throughput: one item
// per cycle while each result is taken as it appears; a waiting result holds off the input.
// Reset (synchronous, active low) empties the list and clears the result valid flag.
// Uses pil_pkg and pil_cell.
`default_nettype none

module positional_insert_erase_list
    import pil_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [CMD_W-1:0]    s_command,
    input  wire logic [POS_W-1:0]    s_position,
    input  wire logic [WORD_W-1:0]   s_value,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [WORD_W-1:0]        m_read_value,
    output logic [STATUS_W-1:0]      m_status,
    output logic [LEN_W-1:0]         m_length
);

    count_t              count_reg, count_next;
    logic                m_valid_reg;
    logic [WORD_W-1:0]   m_read_value_reg, rd_next;
    status_t             m_status_reg, status_next;
    logic [LEN_W-1:0]    m_length_reg;

    value_t              new_value;
    value_t              cell_data [DEPTH];
    cell_sel_t           cell_sel  [DEPTH];
    cmd_t                cmd;
    cmp_t                pos, cnt;
    logic                accept, full, ok;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cmd       = cmd_t'(s_command);
    assign pos       = CMP_W'(s_position);
    assign cnt       = CMP_W'(count_reg);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign new_value = VALUE_WIDTH'(s_value);

    always_comb begin
        status_next = ST_OK;
        unique case (cmd)
            CMD_APPEND: if (full) status_next = ST_FULL;
            CMD_READ:   if (pos >= cnt) status_next = ST_RANGE;
            CMD_ERASE:  if (pos >= cnt) status_next = ST_RANGE;
            CMD_INSERT: begin
                if (pos > cnt) begin
                    status_next = ST_RANGE;
                end else if (full) begin
                    status_next = ST_FULL;
                end
            end
            default:    status_next = ST_OK;
        endcase
    end

    assign ok = accept && (status_next == ST_OK);

    always_comb begin
        count_next = count_reg;
        if (ok) begin
            unique case (cmd)
                CMD_APPEND: count_next = count_reg + CNT_W'(1);
                CMD_INSERT: count_next = count_reg + CNT_W'(1);
                CMD_ERASE:  count_next = count_reg - CNT_W'(1);
                CMD_READ:   count_next = count_reg;
                default:    count_next = count_reg;
            endcase
        end
    end

    always_comb begin
        rd_next = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (CMP_W'(i) == pos) begin
                rd_next = rd_next | WORD_W'(cell_data[i]);
            end
        end
        if (cmd != CMD_READ || status_next != ST_OK) begin
            rd_next = '0;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        cmp_t   idx;
        value_t low_value, high_value;

        assign idx = CMP_W'(g);

        if (g == 0) begin : g_first
            assign low_value = new_value;
        end else begin : g_low
            assign low_value = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign high_value = cell_data[g];
        end else begin : g_high
            assign high_value = cell_data[g+1];
        end

        always_comb begin
            cell_sel[g] = SEL_HOLD;
            if (ok) begin
                unique case (cmd)
                    CMD_APPEND: if (idx == cnt) cell_sel[g] = SEL_LOAD;
                    CMD_ERASE: begin
                        if (idx >= pos && (idx + CMP_W'(1)) < cnt) begin
                            cell_sel[g] = SEL_FROM_HIGH;
                        end
                    end
                    CMD_INSERT: begin
                        if (idx == pos) begin
                            cell_sel[g] = SEL_LOAD;
                        end else if (idx > pos && idx <= cnt) begin
                            cell_sel[g] = SEL_FROM_LOW;
                        end
                    end
                    CMD_READ:   cell_sel[g] = SEL_HOLD;
                    default:    cell_sel[g] = SEL_HOLD;
                endcase
            end
        end

        pil_cell u_cell (
            .aclk       (aclk),
            .sel        (cell_sel[g]),
            .new_value  (new_value),
            .low_value  (low_value),
            .high_value (high_value),
            .data       (cell_data[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_read_value_reg <= rd_next;
            m_status_reg     <= status_next;
            m_length_reg     <= LEN_W'(count_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_length     = m_length_reg;

endmodule

`default_nettype wire

@@ tb/tb_positional_insert_erase_list.sv @@
// Self-checking testbench for positional_insert_erase_list: directed corner cases, then
// random command streams under handshake stalls, checked against an in-bench list model.
// Depends on pil_pkg and the positional_insert_erase_list RTL.
module tb_positional_insert_erase_list;
    import pil_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;

    typedef struct {
        logic [WORD_W-1:0] read_value;
        status_t           status;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    class list_scoreboard;
        value_t       entries[DEPTH];
        int           fill = 0;
        int           max_fill = 0;
        list_result_t expected_q[$];
        int           errors = 0;
        int           shown = 0;
        int           checked = 0;
        int           cmd_seen[4] = '{0, 0, 0, 0};
        int           st_seen[3] = '{0, 0, 0};

        function int pending();
            return expected_q.size();
        endfunction

        function void note_command(cmd_t cmd, logic [POS_W-1:0] pos, logic [WORD_W-1:0] val);
            list_result_t res;
            int           idx;
            int           i;
            idx = int'(pos);
            res.read_value = '0;
            res.status = ST_OK;
            case (cmd)
                CMD_APPEND: begin
                    if (fill >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        entries[fill] = value_t'(val);
                        fill++;
                    end
                end
                CMD_READ: begin
                    if (idx >= fill) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.read_value = WORD_W'(entries[idx]);
                    end
                end
                CMD_ERASE: begin
                    if (idx >= fill) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (i = idx; i + 1 < fill; i++) entries[i] = entries[i + 1];
                        fill--;
                    end
                end
                default: begin
                    if (idx > fill) begin
                        res.status = ST_RANGE;
                    end else if (fill >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        for (i = fill; i > idx; i--) entries[i] = entries[i - 1];
                        entries[idx] = value_t'(val);
                        fill++;
                    end
                end
            endcase
            res.length = LEN_W'(fill);
            if (fill > max_fill) max_fill = fill;
            cmd_seen[int'(cmd)]++;
            st_seen[int'(res.status)]++;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [WORD_W-1:0] rd, logic [STATUS_W-1:0] st,
                                   logic [LEN_W-1:0] len);
            list_result_t exp_res;
            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("ERROR: unexpected result transfer: read_value=%h status=%0d length=%0d",
                             rd, st, len);
                end
                return;
            end
            exp_res = expected_q.pop_front();
            if (rd !== exp_res.read_value || st !== exp_res.status || len !== exp_res.length)
            begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("ERROR: result mismatch at %0t: expected read_value=%h status=%0d %s",
                             $realtime, exp_res.read_value, exp_res.status,
                             $sformatf("length=%0d, got read_value=%h status=%0d length=%0d",
                                       exp_res.length, rd, st, len));
                end
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command = '0;
    logic [POS_W-1:0]     s_position = '0;
    logic [WORD_W-1:0]    s_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [WORD_W-1:0]    m_read_value;
    logic [STATUS_W-1:0]  m_status;
    logic [LEN_W-1:0]     m_length;

    list_scoreboard sb = new;
    bit             rx_hold_req = 1'b0;
    bit             rx_holding = 1'b0;
    bit             rx_steady = 1'b0;
    int             idle_cycles = 0;

    positional_insert_erase_list i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_length     (m_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_command(cmd_t'(s_command), s_position, s_value);
            if (m_valid && m_ready) sb.check_result(m_read_value, m_status, m_length);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("positional_insert_erase_list test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        forever begin
            if (rx_hold_req) begin
                rx_holding = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
                rx_holding = 1'b0;
                rx_hold_req = 1'b0;
            end else if (rx_steady) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 16)) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else begin
                repeat ($urandom_range(1, 16)) begin
                    @(negedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    task automatic transfer_fields(cmd_t cmd, logic [POS_W-1:0] pos, logic [WORD_W-1:0] val);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_position <= pos;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_item(cmd_t cmd, logic [POS_W-1:0] pos, logic [WORD_W-1:0] val);
        @(negedge aclk);
        transfer_fields(cmd, pos, val);
    endtask

    task automatic sender_idle(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // Bias 1 favors growing the list, 2 favors shrinking it, 0 is even.
    task automatic send_random(int bias);
        cmd_t              cmd;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] val;
        int                len;
        int                r;
        int                p_sel;
        @(negedge aclk);
        len = sb.fill;
        r = $urandom_range(0, 99);
        case (bias)
            1: cmd = (r < 35) ? CMD_APPEND : (r < 65) ? CMD_INSERT : (r < 85) ? CMD_READ
                                                                                : CMD_ERASE;
            2: cmd = (r < 15) ? CMD_APPEND : (r < 30) ? CMD_INSERT : (r < 55) ? CMD_READ
                                                                                : CMD_ERASE;
            default: cmd = cmd_t'(r % 4);
        endcase
        p_sel = $urandom_range(0, 99);
        if (p_sel < 10) begin
            pos = POS_W'($urandom_range(0, 31));
        end else if (p_sel < 15) begin
            pos = POS_W'(len);
        end else if (cmd == CMD_INSERT) begin
            pos = POS_W'($urandom_range(0, len));
        end else begin
            pos = (len > 0) ? POS_W'($urandom_range(0, len - 1)) : '0;
        end
        r = $urandom_range(0, 19);
        val = (r == 0) ? '0 : (r == 1) ? '1 : WORD_W'($urandom);
        transfer_fields(cmd, pos, val);
    endtask

    task automatic run_random(int count, bit sender_gaps);
        int n;
        for (n = 0; n < count; n++) begin
            if (sender_gaps && $urandom_range(0, 9) == 0) sender_idle($urandom_range(1, 16));
            send_random(((n / 40) % 3 == 0) ? 1 : ((n / 40) % 3 == 1) ? 2 : 0);
        end
    endtask

    initial begin
        int k;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(CMD_READ, 5'd0, 32'h0000_1111);
        send_item(CMD_ERASE, 5'd0, 32'h0000_2222);
        send_item(CMD_INSERT, 5'd1, 32'h0000_3333);
        send_item(CMD_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_item(CMD_APPEND, 5'd31, 32'h0000_0000);
        send_item(CMD_INSERT, 5'd2, 32'hA5A5_A5A5);
        send_item(CMD_INSERT, 5'd1, 32'h5A5A_5A5A);
        send_item(CMD_READ, 5'd3, 32'hFFFF_FFFF);
        send_item(CMD_READ, 5'd4, 32'h0000_0000);
        for (k = 4; k < DEPTH; k++) send_item(CMD_APPEND, POS_W'(k), WORD_W'($urandom));
        send_item(CMD_APPEND, 5'd0, 32'h1234_5678);
        send_item(CMD_INSERT, 5'd16, 32'h8765_4321);
        send_item(CMD_INSERT, 5'd31, 32'hDEAD_BEEF);
        send_item(CMD_READ, 5'd31, 32'h0000_0000);
        send_item(CMD_ERASE, 5'd15, 32'h0000_0000);
        send_item(CMD_ERASE, 5'd0, 32'h0000_0000);

        run_random(300, 1'b1);

        sender_idle(1);
        wait_drained();

        rx_hold_req = 1'b1;
        wait (rx_holding);
        run_random(40, 1'b0);

        run_random(400, 1'b1);

        rx_steady = 1'b1;
        run_random(150, 1'b0);

        sender_idle(1);
        wait_drained();
        repeat (4) @(posedge aclk);

        $display("Sent %0d appends, %0d reads, %0d erases and %0d inserts; %0d results checked.",
                 sb.cmd_seen[0], sb.cmd_seen[1], sb.cmd_seen[2], sb.cmd_seen[3], sb.checked);
        $display("Out-of-range results: %0d, full results: %0d, longest list: %0d entries.",
                 sb.st_seen[1], sb.st_seen[2], sb.max_fill);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("positional_insert_erase_list test passed");
        end else begin
            $display("%0d mismatches, %0d results still expected", sb.errors, sb.pending());
            $display("positional_insert_erase_list test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pil_pkg.sv
rtl/pil_cell.sv
rtl/positional_insert_erase_list.sv
tb/tb_positional_insert_erase_list.sv
